@@ hw/rtl/double_normalize_round_pack_core_macros.svh @@
// assertion macros for the binary64 normalize, round and pack core
// used by double_normalize_round_pack_core, no other dependencies
`ifndef DOUBLE_NORMALIZE_ROUND_PACK_CORE_MACROS_SVH
`define DOUBLE_NORMALIZE_ROUND_PACK_CORE_MACROS_SVH

// same-cycle implication under the asynchronous reset
`define DNRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dnrp assertion failed");

// next-cycle implication under the asynchronous reset
`define DNRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dnrp assertion failed");

`endif

@@ hw/rtl/dnrp_pkg.sv @@
// shared types and constants of the binary64 normalize, round and pack core
// no dependencies; imported by dnrp_lzc16 and double_normalize_round_pack_core
`default_nettype none

package dnrp_pkg;

	localparam int BEXP_W = 14;
	localparam int RAW_W  = 64;
	localparam int EXP_W  = 11;
	localparam int FRAC_W = 52;
	localparam int SH_W   = 6;

	localparam logic [EXP_W-1:0]         EXP_INF     = 11'd2047;
	localparam logic [EXP_W-1:0]         EXP_ZERO    = 11'd0;
	localparam logic [EXP_W-1:0]         EXP_SUB_CRY = 11'd2;
	localparam logic [RAW_W-1:0]         ROUND_ADD   = 64'h0000_0000_0000_0200;
	localparam logic signed [BEXP_W-1:0] FLUSH_LIMIT = -14'sd53;

	// leading zero result of one 16-bit chunk
	typedef struct packed {
		logic       zero;
		logic [3:0] cnt;
	} lzc_t;

endpackage

`default_nettype wire

@@ hw/rtl/dnrp_lzc16.sv @@
// leading zero counter over one 16-bit chunk of the working fraction
// depends on dnrp_pkg for the lzc_t result type
`default_nettype none

module dnrp_lzc16 import dnrp_pkg::*; (
	input  wire logic [15:0] word,
	output lzc_t             res
);

	always_comb begin
		res.zero = 1'b1;
		res.cnt  = 4'd0;
		// highest set bit wins since it is visited last
		for (int i = 0; i < 16; i++) begin
			if (word[i]) begin
				res.zero = 1'b0;
				res.cnt  = 4'(15 - i);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/double_normalize_round_pack_core.sv @@
// binary64 normalize, round and pack core: five register stages, one transaction
// per cycle while the output is not stalled. A transaction enters each cycle the
// first stage is free and its result leaves from the fifth; the pipeline stages
// are leading zero count, shift selection, left normalize, right denormalize and
// round/pack. Each stage holds its valid bit and only stalls when the stage after
// it is full and stalled, so bubbles close up under output backpressure. Depends
// on dnrp_pkg, dnrp_lzc16 and the assertion macros header.
`default_nettype none
`include "double_normalize_round_pack_core_macros.svh"

module double_normalize_round_pack_core import dnrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // biased_exponent[13:0], raw_fraction[77:14],
	                                   // sign_bit[78], zero pad[79]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata   // sign_out[0], exponent_out[11:1],
	                                   // fraction_out[63:12]
);

	// stage enables
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en_s5    = !v_s5 || m_tready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: register operands with per-chunk leading zero counts
	logic signed [BEXP_W-1:0] in_exp;
	logic [RAW_W-1:0]         in_frac;
	logic                     in_sign;
	lzc_t                     lz_c [4];

	assign in_exp  = $signed(s_tdata[13:0]);
	assign in_frac = s_tdata[77:14];
	assign in_sign = s_tdata[78];

	for (genvar g = 0; g < 4; g++) begin : g_lzc
		dnrp_lzc16 u_lzc (
			.word (in_frac[16*g +: 16]),
			.res  (lz_c[g])
		);
	end

	logic signed [BEXP_W-1:0] e_s1;
	logic [RAW_W-1:0]         f_s1;
	logic                     sg_s1;
	lzc_t                     lz_s1 [4];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			e_s1  <= in_exp;
			f_s1  <= in_frac;
			sg_s1 <= in_sign;
			for (int i = 0; i < 4; i++) lz_s1[i] <= lz_c[i];
		end
	end

	// stage 2: full count, then shift limited by the exponent
	logic [SH_W-1:0] lz_all;
	logic            f_zero;
	logic [SH_W-1:0] sh_sel;

	always_comb begin
		f_zero = 1'b0;
		if (!lz_s1[3].zero)      lz_all = {2'd0, lz_s1[3].cnt};
		else if (!lz_s1[2].zero) lz_all = {2'd1, lz_s1[2].cnt};
		else if (!lz_s1[1].zero) lz_all = {2'd2, lz_s1[1].cnt};
		else begin
			lz_all = {2'd3, lz_s1[0].cnt};
			f_zero = lz_s1[0].zero;
		end
		sh_sel = '0;
		if (e_s1 > 14'sd0 && !f_zero) begin
			if (e_s1 <= $signed({8'd0, lz_all})) sh_sel = e_s1[SH_W-1:0];
			else                                  sh_sel = lz_all;
		end
	end

	logic signed [BEXP_W-1:0] e_s2;
	logic [RAW_W-1:0]         f_s2;
	logic                     sg_s2;
	logic [SH_W-1:0]          sh_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			e_s2  <= e_s1;
			f_s2  <= f_s1;
			sg_s2 <= sg_s1;
			sh_s2 <= sh_sel;
		end
	end

	// stage 3: left normalize
	logic signed [BEXP_W-1:0] e_s3;
	logic [RAW_W-1:0]         f_s3;
	logic                     sg_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			e_s3  <= e_s2 - $signed({8'd0, sh_s2});
			f_s3  <= f_s2 << sh_s2;
			sg_s3 <= sg_s2;
		end
	end

	// stage 4: denormalize below range; a flush is a zero fraction on the same path
	logic            under;
	logic            flush;
	logic [SH_W-1:0] rsh;
	logic [RAW_W-1:0] f_den;

	always_comb begin
		under = (e_s3 < 14'sd0) || (e_s3 == 14'sd0 && !f_s3[RAW_W-1]);
		flush = e_s3 < FLUSH_LIMIT;
		rsh   = SH_W'(-e_s3);
		f_den = f_s3;
		if (flush)                 f_den = '0;
		else if (e_s3 < 14'sd0)    f_den = f_s3 >> rsh;
	end

	logic [BEXP_W-1:0] e_s4;
	logic [RAW_W-1:0]  f_s4;
	logic              sg_s4;
	logic              un_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			e_s4  <= e_s3;
			f_s4  <= f_den;
			sg_s4 <= sg_s3;
			un_s4 <= under;
		end
	end

	// stage 5: round, renormalize on carry, saturate to infinity, pack
	logic [RAW_W-1:0]    fr;
	logic [BEXP_W:0]     e_nxt;
	logic [EXP_W-1:0]    exp_pk;
	logic [FRAC_W-1:0]   frac_pk;

	always_comb begin
		fr      = f_s4 + ROUND_ADD;
		e_nxt   = {1'b0, e_s4} + 15'd1 + {14'd0, fr[RAW_W-1]};
		frac_pk = fr[RAW_W-1] ? fr[62:11] : fr[61:10];
		if (un_s4) begin
			exp_pk = fr[RAW_W-1] ? EXP_SUB_CRY : EXP_ZERO;
		end else if (e_nxt >= 15'(EXP_INF)) begin
			exp_pk  = EXP_INF;
			frac_pk = '0;
		end else begin
			exp_pk = e_nxt[EXP_W-1:0];
		end
	end

	logic              sg_s5;
	logic [EXP_W-1:0]  exp_s5;
	logic [FRAC_W-1:0] frac_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			sg_s5   <= sg_s4;
			exp_s5  <= exp_pk;
			frac_s5 <= frac_pk;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {frac_s5, exp_s5, sg_s5};

	`DNRP_ASSERT_IMP(a_inf_zero_frac, clk, arst_n,
		m_tvalid && exp_s5 == EXP_INF, frac_s5 == '0)
	`DNRP_ASSERT_IMP(a_full_only_when_stalled, clk, arst_n,
		!s_tready, m_tvalid && !m_tready)
	`DNRP_ASSERT_IMP(a_normalized_s3, clk, arst_n,
		v_s3 && e_s3 > 14'sd0, f_s3[RAW_W-1] || f_s3 == '0)
	`DNRP_ASSERT_NXT(a_stall_holds_s5, clk, arst_n,
		v_s5 && !m_tready && v_s4, v_s4)

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// testbench for double_normalize_round_pack_core: drives sign, biased exponent and raw
// fraction transactions and checks each packed binary64 result against a local predictor
// depends on dnrp_pkg and the core rtl only
`timescale 1ns / 100ps

module tb_top;
	import dnrp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int CALM_FROM = 1200;
	localparam logic [RAW_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [RAW_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic              sign;
		logic [EXP_W-1:0]  exponent;
		logic [FRAC_W-1:0] fraction;
	} packed_double_t;

	class dnrp_scoreboard;
		packed_double_t awaited[$];
		int fails;

		function new();
			fails = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		// normalize, denormalize or flush, round at bit 9, then pack
		function packed_double_t pack_binary64(logic signed [BEXP_W-1:0] bexp,
				logic [RAW_W-1:0] frac, logic sgn);
			int e;
			logic [RAW_W-1:0] f;
			packed_double_t r;
			e = bexp;
			f = frac;
			r.sign = sgn;
			r.exponent = EXP_ZERO;
			r.fraction = '0;
			while (e > 0 && f != 0 && !f[RAW_W-1]) begin
				e--;
				f = f << 1;
			end
			if (e < 0 || (e == 0 && !f[RAW_W-1])) begin
				if (e < int'(FLUSH_LIMIT))
					return r;
				if (e < 0) begin
					f = f >> (-e);
					e = 0;
				end
				f = f + ROUND_ADD;
				if (!f[RAW_W-1]) begin
					r.fraction = f[61:10];
					return r;
				end
			end else begin
				f = f + ROUND_ADD;
			end
			e++;
			if (f[RAW_W-1]) begin
				e++;
				f = f >> 1;
			end
			if (e >= int'(EXP_INF)) begin
				r.exponent = EXP_INF;
				return r;
			end
			r.exponent = EXP_W'(e);
			r.fraction = f[61:10];
			return r;
		endfunction

		function void note_operand(logic signed [BEXP_W-1:0] bexp, logic [RAW_W-1:0] frac,
				logic sgn);
			awaited.push_back(pack_binary64(bexp, frac, sgn));
		endfunction

		task check_result(logic [63:0] word);
			packed_double_t got;
			packed_double_t want;
			got.sign = word[0];
			got.exponent = word[11:1];
			got.fraction = word[63:12];
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result %h", word));
			end else begin
				want = awaited.pop_front();
				if (got.sign !== want.sign)
					report($sformatf("sign_out %b, expected %b", got.sign, want.sign));
				if (got.exponent !== want.exponent)
					report($sformatf("exponent_out %0d, expected %0d",
						got.exponent, want.exponent));
				if (got.fraction !== want.fraction)
					report($sformatf("fraction_out %h, expected %h",
						got.fraction, want.fraction));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;  // biased_exponent[13:0], raw_fraction[77:14], sign_bit[78], pad[79]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;       // sign_out[0], exponent_out[11:1], fraction_out[63:12]

	dnrp_scoreboard sb = new();
	int cycles = 0;
	int gap_pct = 20;
	int stall_pct = 20;
	int stall_left = 0;

	double_normalize_round_pack_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("double_normalize_round_pack_core verification failed");
			$finish;
		end
	end

	// result side: check accepted transactions, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(1, 14) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task send_operand(input logic signed [BEXP_W-1:0] bexp, input logic [RAW_W-1:0] frac,
			input logic sgn);
		if ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, sgn, frac, bexp};
		do @(posedge clk); while (!s_tready);
		sb.note_operand(bexp, frac, sgn);
	endtask

	initial begin
		logic signed [BEXP_W-1:0] be;
		logic [RAW_W-1:0] fr;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero fractions, exponent extremes and overflow
		send_operand(14'sd0, 64'h0, 1'b0);
		send_operand(14'sd1, 64'h0, 1'b1);
		send_operand(14'sd2045, 64'h0, 1'b0);
		send_operand(14'sd2046, 64'h0, 1'b1);
		send_operand(14'sd8191, 64'h0, 1'b0);
		send_operand(14'sd8191, ALL_ONES, 1'b1);
		send_operand(-14'sd8192, ALL_ONES, 1'b0);
		send_operand(-14'sd8192, 64'h0, 1'b1);
		// plain normalized values and left normalization
		send_operand(14'sd1023, TOP_BIT, 1'b0);
		send_operand(14'sd0, TOP_BIT, 1'b1);
		send_operand(14'sd1023, 64'h1, 1'b0);
		send_operand(14'sd5, 64'h1, 1'b1);
		// deep underflow edge and subnormals
		send_operand(-14'sd54, TOP_BIT, 1'b0);
		send_operand(-14'sd53, ALL_ONES, 1'b1);
		send_operand(-14'sd10, TOP_BIT, 1'b0);
		// subnormal round carry into exponent 2
		send_operand(14'sd0, 64'h7FFF_FFFF_FFFF_FE00, 1'b1);
		// rounding wraps modulo 2^64
		send_operand(14'sd100, ALL_ONES, 1'b0);
		send_operand(14'sd100, 64'hFFFF_FFFF_FFFF_FE00, 1'b1);
		// rounding carry in the normal path, and into overflow
		send_operand(14'sd300, 64'hFFFF_FFFF_FFFF_FC00, 1'b0);
		send_operand(14'sd2045, 64'hFFFF_FFFF_FFFF_FC00, 1'b1);
		send_operand(14'sd2046, TOP_BIT, 1'b0);
		send_operand(14'sd0, 64'h5555_5555_5555_5555, 1'b1);
		send_operand(-14'sd1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= CALM_FROM) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ((i / 150) % 3)
					0: begin gap_pct = 25; stall_pct = 25; end
					1: begin gap_pct = 8; stall_pct = 40; end
					default: begin gap_pct = 0; stall_pct = 0; end
				endcase
			end

			case ($urandom_range(0, 9))
				0: be = BEXP_W'($urandom);
				5: be = BEXP_W'(int'($urandom_range(0, 12)) - 6);
				6, 7: be = BEXP_W'(int'($urandom_range(2030, 2060)));
				8: be = BEXP_W'(int'($urandom_range(0, 10)) - 58);
				9: be = $urandom_range(0, 1) ? BEXP_W'(-8192 + int'($urandom_range(0, 3)))
				                            : BEXP_W'(8191 - int'($urandom_range(0, 3)));
				default: be = BEXP_W'(int'($urandom_range(0, 2200)) - 60);
			endcase

			fr = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: fr = '0;
				1: fr = ALL_ONES >> $urandom_range(0, 63);
				2: fr = (ALL_ONES >> $urandom_range(0, 63)) ^ (64'h1 << $urandom_range(0, 15));
				3: fr = 64'h1 << $urandom_range(0, 63);
				4, 5, 6: fr = fr >> $urandom_range(0, 63);
				default: ;
			endcase

			send_operand(be, fr, 1'($urandom));
		end
		s_tvalid <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.fails == 0)
			$display("double_normalize_round_pack_core verification clean");
		else
			$display("double_normalize_round_pack_core verification failed");
		$finish;
	end

endmodule
